FILE: rtl/pwle_pkg.sv
package pwle_pkg;

  localparam int unsigned MaxKnots = 64;
  localparam int unsigned IdxW = $clog2(MaxKnots);
  localparam int unsigned CntW = $clog2(MaxKnots + 1);
  localparam int unsigned DivW = 64;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

FILE: rtl/piecewise_linear_envelope_unit.sv
// Piecewise linear envelope: knots (time, level) are stored in time order in two
// 64-entry synchronous memories. Each transaction gives exactly one result strobe;
// the receiver cannot stall. An add shifts later knots up one entry at a time (read
// then write); an add to a full table moves no knots. A query reads and checks one
// entry at a time until the bracketing segment is found, forms the 64-bit product,
// then runs a one-bit-per-cycle restoring division by the segment length. The divider
// and the memory read port set the rate; busy is high from the accepting edge until
// the result strobe, and a new transaction can be taken in the strobe cycle.
module piecewise_linear_envelope_unit
  import pwle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] knot_value_i,
  output logic               valid_o,
  output logic signed [31:0] level_o,
  output logic [1:0]         status_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ARD   = 9'b000000010,
    S_AWR   = 9'b000000100,
    S_QRD   = 9'b000001000,
    S_QCHK  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] t_mem [MaxKnots];
  logic [31:0] v_mem [MaxKnots];
  logic [31:0] t_rd_q, v_rd_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_t, wr_v;
  logic we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      t_mem[wr_addr] <= wr_t;
      v_mem[wr_addr] <= wr_v;
    end
    t_rd_q <= t_mem[rd_addr];
    v_rd_q <= v_mem[rd_addr];
  end

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            mode_q;
  logic signed [31:0] pos_q, val_q;
  logic signed [31:0] t0_q, t0_d, v0_q, v0_d;
  logic signed [32:0] dt_q, dt_d, dp_q, dp_d;
  logic               neg_q, neg_d;
  logic [32:0]        mag_q, mag_d;
  logic [DivW-1:0]    num_q, num_d;
  logic [DivW:0]      rem_q, rem_d;
  logic [6:0]         bit_q, bit_d;
  logic               valid_q, valid_d;
  logic signed [31:0] level_q, level_d;
  logic [1:0]         status_q, status_d;
  logic signed [32:0] dv;
  logic [DivW:0]      rem_sh;

  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign level_o  = level_q;
  assign status_o = status_q;

  assign dv = 33'(signed'(v_rd_q)) - 33'(v0_q);
  assign rem_sh = {rem_q[DivW-1:0], num_q[DivW-1]};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q;
    t0_d = t0_q; v0_d = v0_q; dt_d = dt_q; dp_d = dp_q; neg_d = neg_q; mag_d = mag_q;
    num_d = num_q; rem_d = rem_q; bit_d = bit_q;
    valid_d = 1'b0; level_d = level_q; status_d = status_q;
    rd_addr = idx_q[IdxW-1:0]; wr_addr = idx_q[IdxW-1:0];
    wr_t = t_rd_q; wr_v = v_rd_q; we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          level_d = '0; status_d = STATUS_OK;
          if (!mode_i) begin
            if (cnt_q >= CntW'(MaxKnots)) begin
              status_d = STATUS_FULL; state_d = S_DONE;
            end else if (cnt_q == '0) begin
              idx_d = '0; state_d = S_AWR;
            end else begin
              idx_d = cnt_q; state_d = S_ARD;
            end
          end else if (cnt_q == '0) begin
            status_d = STATUS_EMPTY; state_d = S_DONE;
          end else begin
            idx_d = '0; state_d = S_QRD;
          end
        end
      end
      S_ARD: begin
        rd_addr = IdxW'(idx_q - 1'b1);
        state_d = S_AWR;
      end
      S_AWR: begin
        if (idx_q != '0 && $signed(t_rd_q) > pos_q) begin
          we = 1'b1;
          idx_d = idx_q - 1'b1;
          state_d = (idx_q == CntW'(1)) ? S_AWR : S_ARD;
          if (idx_q == CntW'(1)) begin
            state_d = S_AWR;
          end
        end else begin
          we = 1'b1; wr_t = pos_q; wr_v = val_q;
          cnt_d = cnt_q + 1'b1;
          state_d = S_DONE;
        end
        if (idx_q == CntW'(1) && we && wr_t == t_rd_q && $signed(t_rd_q) > pos_q) begin
          // Entry 0 moved up; next cycle writes the new knot at entry 0.
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (mode_q) begin
          if (neg_q) level_d = v0_q - num_q[31:0];
          else       level_d = v0_q + num_q[31:0];
          state_d = S_DONE;
        end else begin
          we = 1'b1; wr_addr = '0; wr_t = pos_q; wr_v = val_q;
          cnt_d = cnt_q + 1'b1;
          state_d = S_DONE;
        end
      end
      S_QRD: begin
        state_d = S_QCHK;
      end
      S_QCHK: begin
        if (idx_q == '0) begin
          if (pos_q < $signed(t_rd_q) || cnt_q < CntW'(2)) begin
            level_d = v_rd_q; state_d = S_DONE;
          end else begin
            t0_d = t_rd_q; v0_d = v_rd_q;
            idx_d = CntW'(1); rd_addr = IdxW'(1); state_d = S_QRD;
          end
        end else if (pos_q <= $signed(t_rd_q)) begin
          dt_d = 33'(signed'(t_rd_q)) - 33'(t0_q);
          dp_d = 33'(pos_q) - 33'(t0_q);
          neg_d = dv[32];
          mag_d = dv[32] ? 33'(-dv) : 33'(dv);
          if (t_rd_q == t0_q) begin
            level_d = v0_q; state_d = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end else if (idx_q == cnt_q - 1'b1) begin
          level_d = v_rd_q; state_d = S_DONE;
        end else begin
          t0_d = t_rd_q; v0_d = v_rd_q;
          idx_d = idx_q + 1'b1; rd_addr = IdxW'(idx_q + 1'b1); state_d = S_QRD;
        end
      end
      S_MUL: begin
        num_d = DivW'(dp_q[31:0]) * DivW'(mag_q[31:0]);
        rem_d = '0; bit_d = 7'(DivW); state_d = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {32'b0, dt_q[32:0]}) begin
          rem_d = rem_sh - {32'b0, dt_q[32:0]};
          num_d = {num_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          num_d = {num_q[DivW-2:0], 1'b0};
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == 7'd1) state_d = S_FIN;
      end
      S_DONE: begin
        valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      mode_q <= mode_i; pos_q <= position_i; val_q <= knot_value_i;
    end
    idx_q <= idx_d; t0_q <= t0_d; v0_q <= v0_d; dt_q <= dt_d; dp_q <= dp_d;
    neg_q <= neg_d; mag_q <= mag_d; num_q <= num_d; rem_q <= rem_d; bit_q <= bit_d;
    level_q <= level_d; status_q <= status_d;
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxKnots)) else $error("knot count overflow");
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe longer than one cycle");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("transaction not taken");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !busy) else $error("busy during result strobe");
`endif

endmodule

FILE: verif/piecewise_linear_envelope_unit_test.sv
module piecewise_linear_envelope_unit_test
  import pwle_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        mode;
    logic [31:0] position;
    logic [31:0] knot_value;
    logic        known;
    logic [31:0] level;
    status_e     status;
  } stim_row_t;

  typedef struct {
    logic [31:0] level;
    status_e     status;
  } envelope_out_t;

  localparam logic ModeAdd = 1'b0;
  localparam logic ModeQuery = 1'b1;
  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic mode_i;
  logic signed [31:0] position_i;
  logic signed [31:0] knot_value_i;
  logic valid_o;
  logic signed [31:0] level_o;
  logic [1:0] status_o;

  logic signed [31:0] env_times [MaxKnots];
  logic signed [31:0] env_levels [MaxKnots];
  int env_count;
  envelope_out_t expected_q[$];
  int errors;
  int cycles;

  piecewise_linear_envelope_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .position_i(position_i), .knot_value_i(knot_value_i),
    .valid_o(valid_o), .level_o(level_o), .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] segment_level(
      logic signed [31:0] pos, logic signed [31:0] t0, logic signed [31:0] t1,
      logic signed [31:0] v0, logic signed [31:0] v1);
    logic [32:0] span;
    logic [32:0] offset;
    logic signed [33:0] rise;
    logic [32:0] rise_mag;
    logic [65:0] prod;
    logic [65:0] quot;
    logic signed [33:0] res;
    span = 33'(34'(t1) - 34'(t0));
    offset = 33'(34'(pos) - 34'(t0));
    rise = 34'(v1) - 34'(v0);
    if (span == 0) return v0;
    rise_mag = rise < 0 ? 33'(-rise) : 33'(rise);
    prod = 66'(offset) * 66'(rise_mag);
    quot = prod / 66'(span);
    res = rise < 0 ? 34'(v0) - 34'(quot) : 34'(v0) + 34'(quot);
    return res[31:0];
  endfunction

  function automatic envelope_out_t envelope_step(logic mode, logic signed [31:0] pos,
                                                  logic signed [31:0] value);
    envelope_out_t r;
    int at;
    r.level = '0;
    r.status = STATUS_OK;
    if (mode == ModeAdd) begin
      if (env_count >= MaxKnots) begin
        r.status = STATUS_FULL;
      end else begin
        at = env_count;
        while (at > 0 && env_times[at-1] > pos) at--;
        for (int i = env_count; i > at; i--) begin
          env_times[i] = env_times[i-1];
          env_levels[i] = env_levels[i-1];
        end
        env_times[at] = pos;
        env_levels[at] = value;
        env_count++;
      end
    end else if (env_count == 0) begin
      r.status = STATUS_EMPTY;
    end else if (pos < env_times[0] || env_count < 2) begin
      r.level = env_levels[0];
    end else begin
      r.level = env_levels[env_count-1];
      for (int i = 0; i + 1 < env_count; i++) begin
        if (pos <= env_times[i+1]) begin
          r.level = segment_level(pos, env_times[i], env_times[i+1],
                                  env_levels[i], env_levels[i+1]);
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(logic mode, logic [31:0] pos, logic [31:0] value,
                           logic known, logic [31:0] lvl, status_e st);
    envelope_out_t e;
    e = envelope_step(mode, pos, value);
    if (known && (e.level !== lvl || e.status !== st)) begin
      $display("%0t tb row mismatch: expected %h/%0d actual %h/%0d", $time, lvl, st,
               e.level, e.status);
      errors++;
    end
    expected_q.push_back(e);
    start <= 1'b1;
    mode_i <= mode;
    position_i <= pos;
    knot_value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    envelope_out_t e;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: level %h status %0d", $time, level_o, status_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (level_o !== e.level) begin
          $display("%0t level mismatch: expected %h actual %h", $time, e.level, level_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, e.status,
                   status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t rows[$];

  function automatic stim_row_t row(logic m, logic [31:0] p, logic [31:0] v, logic k,
                                    logic [31:0] l, status_e s);
    stim_row_t r;
    r.mode = m; r.position = p; r.knot_value = v; r.known = k; r.level = l; r.status = s;
    return r;
  endfunction

  initial begin
    logic m;
    logic [31:0] p;
    logic [31:0] v;
    int kind;
    env_count = 0;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = ModeAdd;
    position_i = '0;
    knot_value_i = '0;
    rows.push_back(row(ModeQuery, 32'h0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY));
    rows.push_back(row(ModeAdd, 32'h0000_0100, 32'h7fff_ffff, 1'b1, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h8000_0000, 32'h0, 1'b1, 32'h7fff_ffff, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h7fff_ffff, 32'h0, 1'b1, 32'h7fff_ffff, STATUS_OK));
    rows.push_back(row(ModeAdd, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0, STATUS_OK));
    rows.push_back(row(ModeAdd, 32'h8000_0000, 32'h0001_0000, 1'b1, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h8000_0000, 32'h0, 1'b1, 32'h0001_0000, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h0000_0000, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h4000_0000, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h7fff_fffe, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeAdd, 32'h0000_0100, 32'h0000_1234, 1'b1, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h0000_0100, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h0000_00ff, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'h0000_0101, 32'h0, 1'b0, 32'h0, STATUS_OK));
    rows.push_back(row(ModeQuery, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, STATUS_OK));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_item(rows[i].mode, rows[i].position, rows[i].knot_value, rows[i].known,
                rows[i].level, rows[i].status);
      idle_gap();
    end
    for (int n = 0; n < 450; n++) begin
      if (n == 200) begin
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
        repeat (150) @(posedge clk_i);
      end
      kind = $urandom_range(0, 9);
      m = (env_count >= MaxKnots) ? ($urandom_range(0, 5) != 0) : kind < 4 ? ModeAdd
          : ModeQuery;
      if (kind == 9) begin
        p = $urandom();
        v = $urandom();
      end else if (kind == 8) begin
        p = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      end else begin
        p = 32'(int'($urandom_range(0, 4000)) - 2000);
        v = $urandom();
      end
      send_item(m, p, v, 1'b0, '0, STATUS_OK);
      idle_gap();
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pwle_pkg.sv
rtl/piecewise_linear_envelope_unit.sv
verif/piecewise_linear_envelope_unit_test.sv
